// ===== rtl/bhpc_pkg.sv =====
// shared types and constants of the bayer hot pixel clamp
package bhpc_pkg;

	localparam int MAX_LINE_DEF   = 8192;
	localparam int PIXEL_BITS_DEF = 16;

	localparam int PIX_W  = 16;
	localparam int ROW_W  = 14;
	localparam int OCOL_W = 13;
	localparam int LW_W   = 14;
	localparam int FH_W   = 15;
	localparam int CFG_W  = 15;
	localparam int CIDX_W = 1;
	localparam int DIM_W  = 15;

	localparam int SIZE_MIN   = 5;
	localparam int HEIGHT_MAX = 16384;
	localparam int EDGE       = 2;
	localparam int EMIT_MIN   = 2 * EDGE;

	localparam logic [LW_W-1:0] LINE_WIDTH_RST   = LW_W'(8192);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(4096);

	localparam logic [CIDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
	localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             start_of_frame;
	} bhpc_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]  clamped_value;
		logic [ROW_W-1:0]  out_row;
		logic [OCOL_W-1:0] out_col;
		logic              was_changed;
	} bhpc_out_t;

endpackage

// ===== rtl/bhpc_ram.sv =====
// generic simple dual port ram with registered read
module bhpc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

// ===== rtl/bayer_hot_pixel_clamp_core.sv =====
// top level of the bayer hot pixel clamp
//
//  channel   direction  handshake                    payload
//  in        input      in_valid / in_ready          bhpc_in_t  in_data
//  out       output     out_valid / out_ready        bhpc_out_t out_data
//  cfg       input      cfg_wr_en                    cfg_index, cfg_data
//
//  one pixel beat per clock unless stalled; results pass stages 1-3 to the output register
//  line stores are two rams (slots 0/1 and 2/3), both read every beat, one of them written
//  reset clears positions, window taps and pipeline valids; the line stores are not cleared
//  in_ready drops only when the output register holds an untaken result and every stage is full
module bayer_hot_pixel_clamp_core import bhpc_pkg::*; #(
	parameter int MAX_LINE   = MAX_LINE_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bhpc_in_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output bhpc_out_t         out_data,
	input  logic              cfg_wr_en,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int COL_W = $clog2(MAX_LINE);
	localparam int AW    = $clog2(2 * MAX_LINE);
	localparam logic [AW-1:0] LINE_OFS = AW'(MAX_LINE);

	function automatic logic [PIXEL_BITS-1:0] pmin(input logic [PIXEL_BITS-1:0] a,
		input logic [PIXEL_BITS-1:0] b);
		return (b < a) ? b : a;
	endfunction

	function automatic logic [PIXEL_BITS-1:0] pmax(input logic [PIXEL_BITS-1:0] a,
		input logic [PIXEL_BITS-1:0] b);
		return (b > a) ? b : a;
	endfunction

	logic [LW_W-1:0]  line_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [DIM_W-1:0] w_used, h_used;
	logic [ROW_W-1:0] row_c;
	logic [COL_W-1:0] col_c;
	logic [DIM_W-1:0] row_inc, row_wrap, col_inc, ocol_full;
	logic [AW-1:0]    ram_addr;
	logic [PIXEL_BITS-1:0] pix_c;
	logic             accept;

	logic rdy_o, rdy3, rdy2, rdy1;

	// stage 1
	logic                  v_s1, sel_s1, emit_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [ROW_W-1:0]      orow_s1;
	logic [OCOL_W-1:0]     ocol_s1;
	logic [PIXEL_BITS-1:0] rd_x, rd_y, old4, mid2;

	// stage 2
	logic                  v_s2, emit_s2;
	logic [ROW_W-1:0]      orow_s2;
	logic [OCOL_W-1:0]     ocol_s2;
	logic [PIXEL_BITS-1:0] tap_q [3][5];
	logic [PIXEL_BITS-1:0] m0, m1, m2, m3, x0, x1, x2, x3, lo_c, hi_c;

	// stage 3
	logic                  v_s3;
	logic [PIXEL_BITS-1:0] lo_s3, hi_s3, ctr_s3;
	logic [ROW_W-1:0]      orow_s3;
	logic [OCOL_W-1:0]     ocol_s3;

	logic      ov_q;
	bhpc_out_t out_q;

	assign rdy_o    = !ov_q || out_ready;
	assign rdy3     = !v_s3 || rdy_o;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign accept   = in_valid && rdy1;

	assign out_valid = ov_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LINE_WIDTH:   line_width_q   <= cfg_data[LW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated frame size and position of the arriving pixel
	always_comb begin
		if (DIM_W'(line_width_q) < DIM_W'(SIZE_MIN)) begin
			w_used = DIM_W'(SIZE_MIN);
		end else if (DIM_W'(line_width_q) > DIM_W'(MAX_LINE)) begin
			w_used = DIM_W'(MAX_LINE);
		end else begin
			w_used = DIM_W'(line_width_q);
		end
		if (DIM_W'(frame_height_q) < DIM_W'(SIZE_MIN)) begin
			h_used = DIM_W'(SIZE_MIN);
		end else if (DIM_W'(frame_height_q) > DIM_W'(HEIGHT_MAX)) begin
			h_used = DIM_W'(HEIGHT_MAX);
		end else begin
			h_used = DIM_W'(frame_height_q);
		end

		row_wrap = '0;
		if (in_data.start_of_frame) begin
			row_c = '0;
			col_c = '0;
		end else begin
			row_c = (DIM_W'(row_q) >= h_used) ? '0 : row_q;
			col_c = col_q;
			if (DIM_W'(col_q) >= w_used) begin
				col_c    = '0;
				row_wrap = DIM_W'(row_c) + DIM_W'(1);
				row_c    = (row_wrap >= h_used) ? '0 : row_wrap[ROW_W-1:0];
			end
		end

		col_inc   = DIM_W'(col_c) + DIM_W'(1);
		row_inc   = DIM_W'(row_c) + DIM_W'(1);
		ocol_full = DIM_W'(col_c) - DIM_W'(EDGE);
		ram_addr  = row_c[0] ? (LINE_OFS + AW'(col_c)) : AW'(col_c);
		pix_c     = in_data.pixel_value[PIXEL_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= w_used) begin
				col_q <= '0;
				row_q <= (row_inc >= h_used) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= row_c;
			end
		end
	end

	// slots 0/1 live in ram x, slots 2/3 in ram y; row-4 and row-2 never share a ram
	bhpc_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(2 * MAX_LINE)
	) u_ram_x (
		.clk     (clk),
		.wr_en   (accept && !row_c[1]),
		.wr_addr (ram_addr),
		.wr_data (pix_c),
		.rd_en   (accept),
		.rd_addr (ram_addr),
		.rd_data (rd_x)
	);

	bhpc_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(2 * MAX_LINE)
	) u_ram_y (
		.clk     (clk),
		.wr_en   (accept && row_c[1]),
		.wr_addr (ram_addr),
		.wr_data (pix_c),
		.rd_en   (accept),
		.rd_addr (ram_addr),
		.rd_data (rd_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix_c;
			sel_s1  <= row_c[1];
			emit_s1 <= (row_c >= ROW_W'(EMIT_MIN)) && (col_c >= COL_W'(EMIT_MIN));
			orow_s1 <= row_c - ROW_W'(EDGE);
			ocol_s1 <= ocol_full[OCOL_W-1:0];
		end
	end

	assign old4 = sel_s1 ? rd_y : rd_x;
	assign mid2 = sel_s1 ? rd_x : rd_y;

	// window taps shift with each beat entering stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 5; k++) begin
					tap_q[r][k] <= '0;
				end
			end
		end else if (rdy2) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				for (int r = 0; r < 3; r++) begin
					for (int k = 1; k < 5; k++) begin
						tap_q[r][k] <= tap_q[r][k-1];
					end
				end
				tap_q[0][0] <= old4;
				tap_q[1][0] <= mid2;
				tap_q[2][0] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			emit_s2 <= emit_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
		end
	end

	// min/max tree over the eight same color neighbors
	always_comb begin
		m0   = pmin(tap_q[0][0], tap_q[0][2]);
		m1   = pmin(tap_q[0][4], tap_q[1][0]);
		m2   = pmin(tap_q[1][4], tap_q[2][0]);
		m3   = pmin(tap_q[2][2], tap_q[2][4]);
		x0   = pmax(tap_q[0][0], tap_q[0][2]);
		x1   = pmax(tap_q[0][4], tap_q[1][0]);
		x2   = pmax(tap_q[1][4], tap_q[2][0]);
		x3   = pmax(tap_q[2][2], tap_q[2][4]);
		lo_c = pmin(pmin(m0, m1), pmin(m2, m3));
		hi_c = pmax(pmax(x0, x1), pmax(x2, x3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			lo_s3   <= lo_c;
			hi_s3   <= hi_c;
			ctr_s3  <= tap_q[1][2];
			orow_s3 <= orow_s2;
			ocol_s3 <= ocol_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (rdy_o) begin
			ov_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_o) begin
			if (ctr_s3 < lo_s3) begin
				out_q.clamped_value <= PIX_W'(lo_s3);
			end else if (ctr_s3 > hi_s3) begin
				out_q.clamped_value <= PIX_W'(hi_s3);
			end else begin
				out_q.clamped_value <= PIX_W'(ctr_s3);
			end
			out_q.was_changed <= (ctr_s3 < lo_s3) || (ctr_s3 > hi_s3);
			out_q.out_row     <= orow_s3;
			out_q.out_col     <= ocol_s3;
		end
	end

endmodule

// ===== rtl/bhpc_checker.sv =====
// port level checks of the bayer hot pixel clamp and their bind
module bhpc_checker import bhpc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input bhpc_in_t          in_data,
	input logic              out_valid,
	input logic              out_ready,
	input bhpc_out_t         out_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// a stalled pixel beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("pixel beat changed while stalled");

	// input stalls only behind an untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked result");

	// results are interior pixels only
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.out_row >= ROW_W'(EDGE) && out_data.out_col >= OCOL_W'(EDGE))
		else $error("result outside interior");

	// after reset is sampled low, no result is offered and in_ready is high
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && in_ready)
		else $error("handshake active in reset");

endmodule

bind bayer_hot_pixel_clamp_core bhpc_checker u_bhpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
